### design/i2c_master_byte_engine_top_macros.svh
// Assertion macros for the I2C master byte engine.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/i2cm_pkg.sv
// Shared types and constants of the I2C master byte engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cm_pkg;

	// Function codes of an input beat
	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP  = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;
	localparam logic [2:0] FUNC_WACK  = 3'd5;

	// Configuration register indexes
	localparam logic CFG_ACK_TIMEOUT = 1'b0;
	localparam logic CFG_TICKS       = 1'b1;

	// Reset values of configuration registers
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
	localparam logic [15:0] TICKS_RST       = 16'd1;

	localparam int UNIT_W = 19;

	// Command sequencer state
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_STOP  = 6'b000100,
		ST_WRITE = 6'b001000,
		ST_READ  = 6'b010000,
		ST_WACK  = 6'b100000
	} cmd_state_t;

	// Class of an input beat after decode
	typedef enum logic [1:0] {
		CLS_NOP  = 2'd0,
		CLS_TICK = 2'd1,
		CLS_CMD  = 2'd2
	} item_cls_t;

	// Decoded item handed from front to sequencer
	typedef struct packed {
		item_cls_t  cls;
		cmd_state_t cmd;
		logic [7:0] data_byte;
		logic       ack_after_read;
		logic       sda_sample;
	} item_t;

	// Result beat
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] received_byte;
		logic       ack_failed;
		logic       command_rejected;
	} result_t;

endpackage

### design/i2cm_cmd_if.sv
// Input channel of the I2C master byte engine: valid/ready plus item fields.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] data_byte;
	logic       ack_after_read;
	logic       sda_sample;

	modport source (output valid, func, data_byte, ack_after_read, sda_sample, input ready);
	modport sink   (input valid, func, data_byte, ack_after_read, sda_sample, output ready);
endinterface

### design/i2cm_res_if.sv
// Result channel of the I2C master byte engine: valid/ready plus result fields.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] received_byte;
	logic       ack_failed;
	logic       command_rejected;

	modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
		done_res, received_byte, ack_failed, command_rejected, input ready);
	modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
		done_res, received_byte, ack_failed, command_rejected, output ready);
endinterface

### design/i2cm_front.sv
// Front stage: accepts input beats, decodes func into class and command state.
// Depends on i2cm_pkg and i2cm_cmd_if.
`timescale 1ns / 1ps

module i2cm_front
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	i2cm_cmd_if.sink  cmd,
	output logic      push_valid,
	input  logic      push_ready,
	output item_t     push_item
);

	logic  v_s1;
	item_t item_s1;
	item_t dec;

	// Decode the function code
	always_comb begin
		dec.data_byte      = cmd.data_byte;
		dec.ack_after_read = cmd.ack_after_read;
		dec.sda_sample     = cmd.sda_sample;
		dec.cls            = CLS_CMD;
		dec.cmd            = ST_IDLE;
		case (cmd.func)
			FUNC_TICK: begin
				dec.cls = CLS_TICK;
			end
			FUNC_START: dec.cmd = ST_START;
			FUNC_STOP:  dec.cmd = ST_STOP;
			FUNC_WRITE: dec.cmd = ST_WRITE;
			FUNC_READ:  dec.cmd = ST_READ;
			FUNC_WACK:  dec.cmd = ST_WACK;
			default: begin
				dec.cls = CLS_NOP;
			end
		endcase
	end

	assign cmd.ready  = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_item  = item_s1;

	// Hold the decoded beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= dec;
		end
	end

endmodule

### design/i2cm_fifo.sv
// Short queue between front and sequencer; register array, one read pointer.
// Depends on i2cm_pkg for the item type.
`timescale 1ns / 1ps

module i2cm_fifo
	import i2cm_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  item_t                      in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output item_t                      out_item,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH+1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	item_t           mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            push;
	logic            pop;

	assign in_ready  = (cnt_q != CntW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

### design/i2cm_seq.sv
// Back part: bus phase sequencer, configuration registers and result register.
// Depends on i2cm_pkg and i2cm_res_if.
`timescale 1ns / 1ps

module i2cm_seq
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	i2cm_res_if.source  res
);

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	logic [7:0]        ack_timeout_q;
	logic [15:0]       ticks_q;

	cmd_state_t        cmd_q;
	logic [1:0]        phase_q;
	logic [3:0]        bits_q;
	logic [7:0]        shift_q;
	logic [UNIT_W-1:0] cd_q;
	logic [7:0]        poll_q;
	logic              scl_q, sda_q, oe_q, ackc_q, fail_q;
	logic [7:0]        last_q;

	cmd_state_t        n_cmd;
	logic [1:0]        n_phase;
	logic [3:0]        n_bits;
	logic [7:0]        n_shift;
	logic [UNIT_W-1:0] n_cd;
	logic [7:0]        n_poll;
	logic              n_scl, n_sda, n_oe, n_ackc, n_fail;
	logic [7:0]        n_last;
	logic              n_done, n_rej;

	logic [15:0]       tpu;
	logic [UNIT_W-1:0] cd1, cd2, cd4;
	logic [8:0]        poll_inc;

	result_t           res_q;
	logic              res_v_q;
	logic              take;

	// Delay lengths of one, two and four units
	assign tpu      = (ticks_q == '0) ? 16'd1 : ticks_q;
	assign cd1      = {3'b000, tpu};
	assign cd2      = {2'b00, tpu, 1'b0};
	assign cd4      = {1'b0, tpu, 2'b00};
	assign poll_inc = {1'b0, poll_q} + 9'd1;

	assign take    = q_valid && (!res_v_q || res.ready);
	assign q_ready = take;

	// Next bus state for one beat
	always_comb begin
		n_cmd   = cmd_q;
		n_phase = phase_q;
		n_bits  = bits_q;
		n_shift = shift_q;
		n_cd    = cd_q;
		n_poll  = poll_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_oe    = oe_q;
		n_ackc  = ackc_q;
		n_fail  = fail_q;
		n_last  = last_q;
		n_done  = 1'b0;
		n_rej   = 1'b0;
		case (q_item.cls)
			CLS_TICK: begin
				if (cmd_q == ST_IDLE) begin
					n_cmd = cmd_q;
				end else if (cmd_q == ST_WACK && phase_q == PH_2) begin
					// Poll for the acknowledge
					if (!q_item.sda_sample) begin
						n_scl   = 1'b0;
						n_cmd   = ST_IDLE;
						n_phase = PH_0;
						n_cd    = '0;
						n_done  = 1'b1;
					end else if (poll_inc > {1'b0, ack_timeout_q}) begin
						n_fail  = 1'b1;
						n_poll  = '0;
						n_cmd   = ST_STOP;
						n_oe    = 1'b1;
						n_scl   = 1'b0;
						n_sda   = 1'b0;
						n_phase = PH_0;
						n_cd    = cd4;
					end else begin
						n_poll = poll_inc[7:0];
					end
				end else begin
					if (cd_q != '0) begin
						n_cd = cd_q - 1'b1;
					end
					if (n_cd == '0) begin
						case (cmd_q)
							ST_START: begin
								if (phase_q == PH_0) begin
									n_sda = 1'b0; n_phase = PH_1; n_cd = cd4;
								end else begin
									n_scl = 1'b0; n_cmd = ST_IDLE; n_phase = PH_0;
									n_cd = '0; n_done = 1'b1;
								end
							end
							ST_STOP: begin
								if (phase_q == PH_0) begin
									n_scl = 1'b1; n_phase = PH_1; n_cd = cd1;
								end else if (phase_q == PH_1) begin
									n_sda = 1'b1; n_phase = PH_2; n_cd = cd4;
								end else begin
									n_cmd = ST_IDLE; n_phase = PH_0; n_cd = '0; n_done = 1'b1;
								end
							end
							ST_WRITE: begin
								if (phase_q == PH_0) begin
									n_scl = 1'b1; n_phase = PH_1; n_cd = cd2;
								end else if (phase_q == PH_1) begin
									n_scl = 1'b0; n_phase = PH_2; n_cd = cd2;
								end else begin
									n_bits = bits_q + 1'b1;
									if (n_bits >= BITS_PER_BYTE) begin
										n_cmd = ST_IDLE; n_phase = PH_0; n_cd = '0;
										n_done = 1'b1;
									end else begin
										// Shift out the next bit
										n_sda   = shift_q[7];
										n_shift = {shift_q[6:0], 1'b0};
										n_phase = PH_0;
										n_cd    = cd2;
									end
								end
							end
							ST_READ: begin
								if (phase_q == PH_0) begin
									n_scl   = 1'b1;
									n_shift = {shift_q[6:0], q_item.sda_sample};
									n_phase = PH_1;
									n_cd    = cd1;
								end else if (phase_q == PH_1) begin
									n_bits = bits_q + 1'b1;
									n_scl  = 1'b0;
									if (n_bits < BITS_PER_BYTE) begin
										n_phase = PH_0; n_cd = cd2;
									end else begin
										n_last  = shift_q;
										n_oe    = 1'b1;
										n_sda   = !ackc_q;
										n_phase = PH_2;
										n_cd    = cd2;
									end
								end else if (phase_q == PH_2) begin
									n_scl = 1'b1; n_phase = PH_3; n_cd = cd2;
								end else begin
									n_scl = 1'b0; n_cmd = ST_IDLE; n_phase = PH_0;
									n_cd = '0; n_done = 1'b1;
								end
							end
							ST_WACK: begin
								if (phase_q == PH_0) begin
									n_scl = 1'b1; n_phase = PH_1; n_cd = cd1;
								end else begin
									n_phase = PH_2; n_cd = '0;
								end
							end
							default: begin
								n_cmd = ST_IDLE; n_phase = PH_0; n_cd = '0; n_done = 1'b1;
							end
						endcase
					end
				end
			end
			CLS_CMD: begin
				if (cmd_q != ST_IDLE) begin
					n_rej = 1'b1;
				end else begin
					n_cmd  = q_item.cmd;
					n_bits = '0;
					case (q_item.cmd)
						ST_START: begin
							n_oe = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
							n_phase = PH_0; n_cd = cd4;
						end
						ST_STOP: begin
							n_oe = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
							n_phase = PH_0; n_cd = cd4;
						end
						ST_WRITE: begin
							n_oe    = 1'b1;
							n_scl   = 1'b0;
							n_sda   = q_item.data_byte[7];
							n_shift = {q_item.data_byte[6:0], 1'b0};
							n_phase = PH_0;
							n_cd    = cd2;
						end
						ST_READ: begin
							n_oe = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
							n_shift = '0; n_ackc = q_item.ack_after_read;
							n_phase = PH_0; n_cd = cd2;
						end
						default: begin
							n_oe = 1'b0; n_sda = 1'b1; n_poll = '0; n_fail = 1'b0;
							n_phase = PH_0; n_cd = cd1;
						end
					endcase
				end
			end
			default: begin
				n_cmd = cmd_q;
			end
		endcase
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RST;
			ticks_q       <= TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[7:0];
				CFG_TICKS:       ticks_q       <= cfg_wdata;
				default:         ticks_q       <= ticks_q;
			endcase
		end
	end

	// Advance the sequencer on each beat taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= ST_IDLE;
			phase_q <= PH_0;
			bits_q  <= '0;
			shift_q <= '0;
			cd_q    <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			oe_q    <= 1'b1;
			ackc_q  <= 1'b0;
			fail_q  <= 1'b0;
			last_q  <= '0;
		end else if (take) begin
			cmd_q   <= n_cmd;
			phase_q <= n_phase;
			bits_q  <= n_bits;
			shift_q <= n_shift;
			cd_q    <= n_cd;
			poll_q  <= n_poll;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			oe_q    <= n_oe;
			ackc_q  <= n_ackc;
			fail_q  <= n_fail;
			last_q  <= n_last;
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (!res_v_q || res.ready) begin
			res_v_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.scl_level        <= n_scl;
			res_q.sda_level        <= n_sda;
			res_q.sda_drive_enable <= n_oe;
			res_q.busy_res         <= (n_cmd != ST_IDLE);
			res_q.done_res         <= n_done;
			res_q.received_byte    <= n_last;
			res_q.ack_failed       <= n_fail;
			res_q.command_rejected <= n_rej;
		end
	end

	assign res.valid            = res_v_q;
	assign res.scl_level        = res_q.scl_level;
	assign res.sda_level        = res_q.sda_level;
	assign res.sda_drive_enable = res_q.sda_drive_enable;
	assign res.busy_res         = res_q.busy_res;
	assign res.done_res         = res_q.done_res;
	assign res.received_byte    = res_q.received_byte;
	assign res.ack_failed       = res_q.ack_failed;
	assign res.command_rejected = res_q.command_rejected;

endmodule

### design/i2c_master_byte_engine_top.sv
// I2C master byte engine, top level.
//
// Channels: cmd (sink) carries one beat per command or tick: func, data_byte,
// ack_after_read, sda_sample. res (source) returns exactly one result beat per
// input beat, in order: SCL/SDA drive levels, busy, done, received byte, ack
// failure and command rejection. Both use valid/ready; a beat moves when both
// are high. The configuration port (cfg_we, cfg_idx, cfg_wdata) writes the
// ack timeout (index 0) and ticks per delay unit (index 1);
// write it only while the engine is idle.
// An input beat passes through the front register, the queue and the result
// register. Each sequencer step is combinational; it takes one beat per cycle
// unless the receiver stalls. The front register and the queue absorb up to
// QUEUE_DEPTH+1 beats while the receiver stalls; cmd.ready drops when full.
// Reset: bus released (SCL, SDA high, driving), idle, registers at defaults,
// no beats in flight.
// Depends on i2cm_pkg, both channel interfaces, i2cm_front, i2cm_fifo,
// i2cm_seq and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_top_macros.svh"

module i2c_master_byte_engine_top
	import i2cm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	i2cm_cmd_if.sink    cmd,
	i2cm_res_if.source  res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata
);

	logic                             push_valid, push_ready;
	item_t                            push_item;
	logic                             q_valid, q_ready;
	item_t                            q_item;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	i2cm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_item   (push_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item),
		.count     (q_count)
	);

	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.res       (res)
	);

	// Checks on the engine's own logic
	`I2CM_ASSERT_NOW(a_done_idle, res.valid && res.done_res, !res.busy_res, "done while busy")
	`I2CM_ASSERT_NOW(a_rej_busy, res.valid && res.command_rejected, res.busy_res, "reject while idle")
	`I2CM_ASSERT_NOW(a_q_bound, 1'b1, q_count <= QUEUE_DEPTH, "queue overfilled")
	`I2CM_ASSERT_NEXT(a_take_res, q_valid && q_ready, res.valid, "taken beat gave no result")

endmodule

### dv/i2c_master_byte_engine_top_tb.sv
// Testbench of the I2C master byte engine: drives command and tick beats, predicts
// every result beat with a cycle-free bus sequencer model, and compares in order.
// Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2c_master_byte_engine_top.
`timescale 1ns / 1ps

module i2c_master_byte_engine_top_tb;
	import i2cm_pkg::*;

	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] FUNC_NOP6 = 3'd6;
	localparam logic [2:0] FUNC_NOP7 = 3'd7;
	localparam int DRAIN_CAP = 100000;
	localparam int RUN_CYCLES_MAX = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [15:0] cfg_wdata;

	i2cm_cmd_if cmd_ch ();
	i2cm_res_if res_ch ();

	i2c_master_byte_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Traffic shaping, shared with the driver and the receiver process
	int idle_pct;
	int stall_pct;
	int hold_left;

	// Bus sequencer model state
	logic [2:0]  m_cmd;
	logic [3:0]  m_phase;
	logic [3:0]  m_bits;
	logic [7:0]  m_shift;
	logic [18:0] m_count;
	logic [7:0]  m_polls;
	logic        m_scl;
	logic        m_sda;
	logic        m_oe;
	logic        m_ack_sel;
	logic        m_fail;
	logic [7:0]  m_rd_byte;
	logic        m_done;
	logic [7:0]  timeout_polls;
	logic [15:0] tick_per_unit;
	int          work_beats;

	result_t expected_bus[$];
	int      mismatches;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void reset_model();
		m_cmd = CMD_NONE;
		m_phase = '0;
		m_bits = '0;
		m_shift = '0;
		m_count = '0;
		m_polls = '0;
		m_scl = 1'b1;
		m_sda = 1'b1;
		m_oe = 1'b1;
		m_ack_sel = 1'b0;
		m_fail = 1'b0;
		m_rd_byte = '0;
		m_done = 1'b0;
		timeout_polls = ACK_TIMEOUT_RST;
		tick_per_unit = TICKS_RST;
	endfunction

	// Load the unit countdown; a zero unit size counts as one
	function automatic void hold_units(int units, logic [3:0] nxt);
		int t;
		t = (tick_per_unit == 16'd0) ? 1 : int'(tick_per_unit);
		m_phase = nxt;
		m_count = 19'(units * t);
	endfunction

	function automatic void end_cmd();
		m_cmd = CMD_NONE;
		m_phase = '0;
		m_count = '0;
		m_done = 1'b1;
	endfunction

	function automatic void launch_stop();
		m_cmd = FUNC_STOP;
		m_oe = 1'b1;
		m_scl = 1'b0;
		m_sda = 1'b0;
		hold_units(4, 4'd0);
	endfunction

	function automatic void shift_out_bit();
		m_sda = m_shift[7];
		m_shift = {m_shift[6:0], 1'b0};
		hold_units(2, 4'd0);
	endfunction

	// Advance the active command by one phase
	function automatic void step_sequencer(logic sample);
		case (m_cmd)
			FUNC_START: begin
				if (m_phase == 4'd0) begin
					m_sda = 1'b0;
					hold_units(4, 4'd1);
				end else begin
					m_scl = 1'b0;
					end_cmd();
				end
			end
			FUNC_STOP: begin
				if (m_phase == 4'd0) begin
					m_scl = 1'b1;
					hold_units(1, 4'd1);
				end else if (m_phase == 4'd1) begin
					m_sda = 1'b1;
					hold_units(4, 4'd2);
				end else begin
					end_cmd();
				end
			end
			FUNC_WRITE: begin
				if (m_phase == 4'd0) begin
					m_scl = 1'b1;
					hold_units(2, 4'd1);
				end else if (m_phase == 4'd1) begin
					m_scl = 1'b0;
					hold_units(2, 4'd2);
				end else begin
					m_bits = m_bits + 4'd1;
					if (m_bits >= 4'd8) end_cmd();
					else shift_out_bit();
				end
			end
			FUNC_READ: begin
				if (m_phase == 4'd0) begin
					m_scl = 1'b1;
					m_shift = {m_shift[6:0], sample};
					hold_units(1, 4'd1);
				end else if (m_phase == 4'd1) begin
					m_bits = m_bits + 4'd1;
					m_scl = 1'b0;
					if (m_bits < 4'd8) begin
						hold_units(2, 4'd0);
					end else begin
						m_rd_byte = m_shift;
						m_oe = 1'b1;
						m_sda = ~m_ack_sel;
						hold_units(2, 4'd2);
					end
				end else if (m_phase == 4'd2) begin
					m_scl = 1'b1;
					hold_units(2, 4'd3);
				end else begin
					m_scl = 1'b0;
					end_cmd();
				end
			end
			FUNC_WACK: begin
				if (m_phase == 4'd0) begin
					m_scl = 1'b1;
					hold_units(1, 4'd1);
				end else begin
					m_phase = 4'd2;
					m_count = '0;
				end
			end
			default: end_cmd();
		endcase
	endfunction

	// Tick beat: poll for acknowledge, or count down the current phase
	function automatic void bus_tick(logic sample);
		logic [8:0] n;
		if (m_cmd == CMD_NONE) return;
		if (m_cmd == FUNC_WACK && m_phase == 4'd2) begin
			if (!sample) begin
				m_scl = 1'b0;
				end_cmd();
			end else begin
				n = {1'b0, m_polls} + 9'd1;
				if (n > {1'b0, timeout_polls}) begin
					m_fail = 1'b1;
					m_polls = '0;
					launch_stop();
				end else begin
					m_polls = n[7:0];
				end
			end
			return;
		end
		if (m_count != '0) m_count = m_count - 19'd1;
		if (m_count == '0) step_sequencer(sample);
	endfunction

	function automatic void launch_cmd(logic [2:0] f, logic [7:0] d, logic a);
		m_cmd = f;
		m_bits = '0;
		case (f)
			FUNC_START: begin
				m_oe = 1'b1;
				m_sda = 1'b1;
				m_scl = 1'b1;
				hold_units(4, 4'd0);
			end
			FUNC_STOP: launch_stop();
			FUNC_WRITE: begin
				m_oe = 1'b1;
				m_scl = 1'b0;
				m_shift = d;
				shift_out_bit();
			end
			FUNC_READ: begin
				m_oe = 1'b0;
				m_sda = 1'b1;
				m_scl = 1'b0;
				m_shift = '0;
				m_ack_sel = a;
				hold_units(2, 4'd0);
			end
			default: begin
				m_oe = 1'b0;
				m_sda = 1'b1;
				m_polls = '0;
				m_fail = 1'b0;
				hold_units(1, 4'd0);
			end
		endcase
	endfunction

	// Apply one accepted beat to the model and return the bus result it causes
	function automatic result_t predict_bus(logic [2:0] f, logic [7:0] d, logic a, logic s);
		result_t r;
		logic rej;
		rej = 1'b0;
		m_done = 1'b0;
		if (f == FUNC_TICK) begin
			if (m_cmd != CMD_NONE) work_beats++;
			bus_tick(s);
		end else if (f <= FUNC_WACK) begin
			if (m_cmd != CMD_NONE) begin
				rej = 1'b1;
			end else begin
				work_beats++;
				launch_cmd(f, d, a);
			end
		end
		r.scl_level = m_scl;
		r.sda_level = m_sda;
		r.sda_drive_enable = m_oe;
		r.busy_res = (m_cmd != CMD_NONE);
		r.done_res = m_done;
		r.received_byte = m_rd_byte;
		r.ack_failed = m_fail;
		r.command_rejected = rej;
		return r;
	endfunction

	// Offer one beat after a random gap; predict once it is accepted
	task automatic send_beat(logic [2:0] f, logic [7:0] d, logic a, logic s);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= f;
		cmd_ch.data_byte <= d;
		cmd_ch.ack_after_read <= a;
		cmd_ch.sda_sample <= s;
		do @(posedge clk); while (!cmd_ch.ready);
		expected_bus.push_back(predict_bus(f, d, a, s));
	endtask

	// Tick until the command ends; SDA reads high in high_pct of a hundred,
	// with a stray command slipped in now and then
	task automatic run_out(int high_pct, int noise_pct);
		logic [2:0] f;
		while (m_cmd != CMD_NONE) begin
			if ($urandom_range(0, 99) < noise_pct) f = 3'($urandom_range(1, 7));
			else f = FUNC_TICK;
			send_beat(f, 8'($urandom), 1'($urandom), $urandom_range(0, 99) < high_pct);
		end
	endtask

	task automatic issue(logic [2:0] f, logic [7:0] d, logic a, int high_pct);
		send_beat(f, d, a, 1'($urandom));
		run_out(high_pct, 0);
	endtask

	// Drop valid and wait for every expected beat to return
	task automatic settle();
		int n;
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		n = 0;
		while (expected_bus.size() != 0 && n < DRAIN_CAP) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACK_TIMEOUT) timeout_polls = val[7:0];
		else tick_per_unit = val;
	endtask

	// Receiver: random stalls, plus a long hold-off when asked
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Compare each result beat with the oldest prediction
	initial begin : bus_check
		result_t got;
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got = {res_ch.scl_level, res_ch.sda_level, res_ch.sda_drive_enable,
					res_ch.busy_res, res_ch.done_res, res_ch.received_byte,
					res_ch.ack_failed, res_ch.command_rejected};
				if (expected_bus.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with none pending: %p", $time, got);
				end else begin
					want = expected_bus.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: bus result mismatch: want %p got %p",
								$time, want, got);
					end
				end
			end
		end
	end

	// Ticks and no-op codes while idle
	task automatic test_idle_items();
		send_beat(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		send_beat(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
		send_beat(FUNC_NOP6, 8'hFF, 1'b1, 1'b1);
		send_beat(FUNC_NOP7, 8'h00, 1'b0, 1'b0);
	endtask

	// Every command at least once, data extremes, ACK and NACK after read
	task automatic test_commands();
		issue(FUNC_START, 8'h00, 1'b0, 50);
		issue(FUNC_WRITE, 8'hFF, 1'b1, 50);
		issue(FUNC_WRITE, 8'h00, 1'b0, 50);
		issue(FUNC_WRITE, 8'hA5, 1'b0, 50);
		issue(FUNC_READ, 8'h00, 1'b1, 50);
		issue(FUNC_READ, 8'hFF, 1'b0, 100);
		issue(FUNC_READ, 8'h5A, 1'b1, 0);
		issue(FUNC_WACK, 8'h00, 1'b0, 0);
		issue(FUNC_STOP, 8'h00, 1'b0, 50);
	endtask

	// Commands while busy are dropped and flagged
	task automatic test_busy_rejection();
		logic [2:0] f;
		send_beat(FUNC_START, 8'h00, 1'b0, 1'b0);
		for (f = FUNC_START; f <= FUNC_WACK; f++)
			send_beat(f, 8'($urandom), 1'($urandom), 1'($urandom));
		send_beat(FUNC_NOP7, 8'h00, 1'b0, 1'b0);
		run_out(50, 0);
	endtask

	// Acknowledge never comes: fail, then stop; next wait clears the flag
	task automatic test_ack_timeout();
		issue(FUNC_WACK, 8'h00, 1'b0, 100);
		issue(FUNC_WACK, 8'h00, 1'b0, 60);
	endtask

	// Register extremes, a zero unit size and a long unit size
	task automatic test_config_extremes();
		write_reg(CFG_ACK_TIMEOUT, 16'd0);
		issue(FUNC_WACK, 8'h00, 1'b0, 100);
		write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
		issue(FUNC_WACK, 8'h00, 1'b0, 100);
		write_reg(CFG_TICKS, 16'd0);
		issue(FUNC_START, 8'h00, 1'b0, 50);
		issue(FUNC_WRITE, 8'h3C, 1'b0, 50);
		write_reg(CFG_TICKS, 16'd64);
		issue(FUNC_WACK, 8'h00, 1'b0, 0);
		write_reg(CFG_TICKS, 16'd1);
		write_reg(CFG_ACK_TIMEOUT, 16'd250);
	endtask

	// Hold the receiver off while beats keep coming, so the input stalls
	task automatic test_backpressure();
		settle();
		hold_left = 400;
		issue(FUNC_START, 8'h00, 1'b0, 50);
		issue(FUNC_WRITE, 8'($urandom), 1'b0, 50);
		settle();
	endtask

	// Random command sequences with random content and some noise
	task automatic test_random_traffic(int target, logic [7:0] tmo, logic [15:0] tpu);
		int base;
		int r;
		write_reg(CFG_ACK_TIMEOUT, {8'h00, tmo});
		write_reg(CFG_TICKS, tpu);
		base = work_beats;
		while (work_beats - base < target) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				case ($urandom_range(0, 2))
					0: send_beat(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
					1: send_beat(FUNC_NOP6, 8'($urandom), 1'($urandom), 1'($urandom));
					default: send_beat(FUNC_NOP7, 8'($urandom), 1'($urandom), 1'($urandom));
				endcase
			end else begin
				send_beat(3'($urandom_range(FUNC_START, FUNC_WACK)), 8'($urandom),
					1'($urandom), 1'($urandom));
				run_out(75, 4);
			end
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_ACK_TIMEOUT;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_TICK;
		cmd_ch.data_byte = '0;
		cmd_ch.ack_after_read = 1'b0;
		cmd_ch.sda_sample = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		mismatches = 0;
		work_beats = 0;
		reset_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_items();
		test_commands();
		test_busy_rejection();
		test_ack_timeout();
		test_config_extremes();
		test_backpressure();

		// Idling phases: none, sender, receiver, both
		test_random_traffic(150, 8'd3, 16'd1);
		idle_pct = 76;
		test_random_traffic(130, 8'd0, 16'd2);
		idle_pct = 0;
		stall_pct = 76;
		test_random_traffic(130, 8'd255, 16'd0);
		idle_pct = 37;
		stall_pct = 37;
		test_random_traffic(130, 8'($urandom_range(1, 12)), 16'd1);

		settle();
		repeat (20) @(posedge clk);
		if (expected_bus.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#(12.0 * RUN_CYCLES_MAX);
		$display("FAILURE");
		$finish;
	end

endmodule
